FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
// Each macro assumes a clock named clk and an active-low reset named rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The condition must never hold outside reset.
`define ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed");

// The antecedent implies the consequent in the same cycle.
`define ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The antecedent implies the consequent in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_NEVER(lbl, cond)
`define ASSERT_IMPLY(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: hw/rtl/mvn_pkg.sv
package mvn_pkg;

    localparam int IDX_W  = 10;
    localparam int POS_W  = 16;
    localparam int SUM_W  = 48;
    localparam int NRM_W  = 16;

    // Full-scale value of a unit component in Q1.14.
    localparam logic [14:0] UNIT_Q = 15'd16384;

    // Saturation limits of a normal sum, sign-extended to 64 bits.
    localparam logic signed [63:0] SUM_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] SUM_MIN = -64'sh0000_8000_0000_0000;

    // Result status codes.
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_ZERO_LEN = 2'd1;
    localparam logic [1:0] STATUS_SAT      = 2'd2;

    typedef enum logic [1:0] {
        OP_LOAD     = 2'd0,
        OP_TRIANGLE = 2'd1,
        OP_READ     = 2'd2,
        OP_NONE     = 2'd3
    } op_t;

    // What the back end has to do with a queued item.
    typedef enum logic [2:0] {
        KIND_LOAD,
        KIND_TRIANGLE,
        KIND_READ,
        KIND_ZERO_OK,
        KIND_ZERO_LEN
    } kind_t;

    typedef struct packed {
        logic [1:0]              operation;
        logic [IDX_W-1:0]        vertex_index;
        logic [IDX_W-1:0]        corner_b;
        logic [IDX_W-1:0]        corner_c;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
    } in_item_t;

    typedef struct packed {
        logic signed [NRM_W-1:0] normal_x;
        logic signed [NRM_W-1:0] normal_y;
        logic signed [NRM_W-1:0] normal_z;
        logic [1:0]              status;
    } out_item_t;

    typedef struct packed {
        kind_t    kind;
        in_item_t item;
    } q_entry_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] x;
        logic signed [SUM_W-1:0] y;
        logic signed [SUM_W-1:0] z;
    } sum3_t;

    typedef struct packed {
        logic signed [NRM_W-1:0] nx;
        logic signed [NRM_W-1:0] ny;
        logic signed [NRM_W-1:0] nz;
        logic                    zero_len;
    } norm_res_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_LOAD,
        B_TA,
        B_TB,
        B_TC,
        B_TE,
        B_TM,
        B_TF,
        B_NRD,
        B_NWR,
        B_RD,
        B_RW,
        B_RN
    } back_state_t;

    typedef enum logic [2:0] {
        N_IDLE,
        N_SHIFT,
        N_SQUARE,
        N_SQRT,
        N_CHECK,
        N_DSET,
        N_DIV,
        N_DONE
    } norm_state_t;

endpackage

FILE: hw/rtl/mesh_vertex_normals.sv
// Vertex normal engine. An item is taken when start is high and busy is low;
// busy rises only when the two-entry input queue is full. Every item gives
// exactly one result beat, shown for one cycle with result_valid high, in the
// order the items came in; the receiver cannot stall, so it must take each
// beat in that cycle. In the back end a triangle does three position reads and
// three normal read-modify-writes, one table port each. A read runs the
// normalizer: up to 18 range shifts, a 32-step square root and a 15-step
// divider per component; a normal of zero length skips the divider.
// Table contents are undefined until loaded; there is no clearing pass.
module mesh_vertex_normals #(
    parameter int VERTEX_COUNT  = 1024,
    parameter int POSITION_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  mvn_pkg::in_item_t  in_item,
    output logic               busy,
    output logic               result_valid,
    output mvn_pkg::out_item_t result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic              mode_reg;
    logic              head_valid;
    mvn_pkg::q_entry_t head;
    logic              pop;

    // Register file: shading mode at word 0.
    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {31'd0, mode_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b1;
        end
        else if (psel && penable && pwrite && !paddr[2])
        begin
            mode_reg <= pwdata[0];
        end
    end

    mvn_front #(
        .VERTEX_COUNT (VERTEX_COUNT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .in_item    (in_item),
        .busy       (busy),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    mvn_back #(
        .VERTEX_COUNT  (VERTEX_COUNT),
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .shading_mode (mode_reg),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

FILE: hw/rtl/mvn_front.sv
`include "assert_macros.svh"

module mvn_front #(
    parameter int VERTEX_COUNT = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  mvn_pkg::in_item_t  in_item,
    output logic               busy,
    output logic               head_valid,
    output mvn_pkg::q_entry_t  head,
    input  logic               pop
);

    logic                 push;
    logic                 a_ok;
    logic                 b_ok;
    logic                 c_ok;
    mvn_pkg::kind_t       kind;
    mvn_pkg::q_entry_t    q_mem_reg [2];
    logic                 wr_ptr_reg;
    logic                 rd_ptr_reg;
    logic [1:0]           count_reg;
    logic [1:0]           count_next;

    // Range checks of the indexes against the table depth.
    assign a_ok = 17'(in_item.vertex_index) < 17'(VERTEX_COUNT);
    assign b_ok = 17'(in_item.corner_b) < 17'(VERTEX_COUNT);
    assign c_ok = 17'(in_item.corner_c) < 17'(VERTEX_COUNT);

    // Classify the beat so the back end only sees work it must carry out.
    always_comb
    begin
        unique case (mvn_pkg::op_t'(in_item.operation))
            mvn_pkg::OP_LOAD:
                kind = a_ok ? mvn_pkg::KIND_LOAD : mvn_pkg::KIND_ZERO_OK;
            mvn_pkg::OP_TRIANGLE:
                kind = (a_ok && b_ok && c_ok) ? mvn_pkg::KIND_TRIANGLE
                                              : mvn_pkg::KIND_ZERO_OK;
            mvn_pkg::OP_READ:
                kind = a_ok ? mvn_pkg::KIND_READ : mvn_pkg::KIND_ZERO_LEN;
            default:
                kind = mvn_pkg::KIND_ZERO_OK;
        endcase
    end

    // Two-entry queue toward the back end.
    assign busy       = (count_reg == 2'd2);
    assign push       = start && !busy;
    assign head_valid = (count_reg != 2'd0);
    assign head       = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    // Queue payload storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= '{kind: kind, item: in_item};
        end
    end

    `ASSERT_NEVER(a_count_range, count_reg == 2'd3)
    `ASSERT_IMPLY(a_pop_nonempty, pop, count_reg != 2'd0)
    `ASSERT_NEXT(a_push_grows, push && !pop, count_reg == $past(count_reg) + 2'd1)

endmodule

FILE: hw/rtl/mvn_norm.sv
module mvn_norm (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               go,
    input  mvn_pkg::sum3_t     sums,
    output logic               done,
    output mvn_pkg::norm_res_t res
);

    mvn_pkg::norm_state_t state_reg;
    mvn_pkg::norm_state_t state_next;

    logic [47:0]        mag_reg [3];
    logic [47:0]        mag_next [3];
    logic               neg_reg [3];
    logic               neg_next [3];
    logic [1:0]         comp_reg;
    logic [1:0]         comp_next;
    logic [63:0]        sum_reg;
    logic [63:0]        sum_next;
    logic [63:0]        n_reg;
    logic [63:0]        n_next;
    logic [63:0]        root_reg;
    logic [63:0]        root_next;
    logic [63:0]        bit_reg;
    logic [63:0]        bit_next;
    logic [31:0]        len_reg;
    logic [31:0]        len_next;
    logic [45:0]        num_reg;
    logic [45:0]        num_next;
    logic [45:0]        div_reg;
    logic [45:0]        div_next;
    logic [14:0]        q_reg;
    logic [14:0]        q_next;
    logic [3:0]         step_reg;
    logic [3:0]         step_next;
    logic signed [15:0] nrm_reg [3];
    logic signed [15:0] nrm_next [3];
    logic               zero_reg;
    logic               zero_next;

    logic [47:0]        mag_sel;
    logic               neg_sel;
    logic [59:0]        square;
    logic [63:0]        trial;
    logic               ge;
    logic [14:0]        q_fin;
    logic [14:0]        q_clamp;
    logic               any_big;

    assign done = (state_reg == mvn_pkg::N_DONE);
    assign res  = '{nx: nrm_reg[0], ny: nrm_reg[1], nz: nrm_reg[2], zero_len: zero_reg};

    // Component picked by the shared squarer and divider.
    always_comb
    begin
        unique case (comp_reg)
            2'd0:    begin mag_sel = mag_reg[0]; neg_sel = neg_reg[0]; end
            2'd1:    begin mag_sel = mag_reg[1]; neg_sel = neg_reg[1]; end
            default: begin mag_sel = mag_reg[2]; neg_sel = neg_reg[2]; end
        endcase
    end

    assign square  = mag_sel[29:0] * mag_sel[29:0];
    assign trial   = root_reg + bit_reg;
    assign ge      = (num_reg >= div_reg);
    assign q_fin   = {q_reg[13:0], ge};
    assign q_clamp = (q_fin > mvn_pkg::UNIT_Q) ? mvn_pkg::UNIT_Q : q_fin;
    assign any_big = (mag_reg[0][47:30] != '0) || (mag_reg[1][47:30] != '0)
                  || (mag_reg[2][47:30] != '0);

    // Sequencer: shift into range, sum of squares, square root, then divides.
    always_comb
    begin
        state_next = state_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        comp_next  = comp_reg;
        sum_next   = sum_reg;
        n_next     = n_reg;
        root_next  = root_reg;
        bit_next   = bit_reg;
        len_next   = len_reg;
        num_next   = num_reg;
        div_next   = div_reg;
        q_next     = q_reg;
        step_next  = step_reg;
        nrm_next   = nrm_reg;
        zero_next  = zero_reg;
        unique case (state_reg)
            mvn_pkg::N_IDLE:
            begin
                if (go)
                begin
                    neg_next[0] = sums.x[47];
                    neg_next[1] = sums.y[47];
                    neg_next[2] = sums.z[47];
                    mag_next[0] = sums.x[47] ? 48'(-sums.x) : 48'(sums.x);
                    mag_next[1] = sums.y[47] ? 48'(-sums.y) : 48'(sums.y);
                    mag_next[2] = sums.z[47] ? 48'(-sums.z) : 48'(sums.z);
                    state_next  = mvn_pkg::N_SHIFT;
                end
            end
            mvn_pkg::N_SHIFT:
            begin
                if (any_big)
                begin
                    mag_next[0] = mag_reg[0] >> 1;
                    mag_next[1] = mag_reg[1] >> 1;
                    mag_next[2] = mag_reg[2] >> 1;
                end
                else
                begin
                    comp_next  = 2'd0;
                    sum_next   = '0;
                    state_next = mvn_pkg::N_SQUARE;
                end
            end
            mvn_pkg::N_SQUARE:
            begin
                sum_next = sum_reg + 64'(square);
                if (comp_reg == 2'd2)
                begin
                    n_next     = sum_reg + 64'(square);
                    root_next  = '0;
                    bit_next   = 64'd1 << 62;
                    state_next = mvn_pkg::N_SQRT;
                end
                else
                begin
                    comp_next = comp_reg + 2'd1;
                end
            end
            mvn_pkg::N_SQRT:
            begin
                if (n_reg >= trial)
                begin
                    n_next    = n_reg - trial;
                    root_next = (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg[0])
                begin
                    state_next = mvn_pkg::N_CHECK;
                end
            end
            mvn_pkg::N_CHECK:
            begin
                len_next  = root_reg[31:0];
                comp_next = 2'd0;
                if (root_reg == '0)
                begin
                    zero_next  = 1'b1;
                    nrm_next   = '{default: '0};
                    state_next = mvn_pkg::N_DONE;
                end
                else
                begin
                    zero_next  = 1'b0;
                    state_next = mvn_pkg::N_DSET;
                end
            end
            mvn_pkg::N_DSET:
            begin
                num_next   = {2'b00, mag_sel[29:0], 14'd0} + 46'(len_reg >> 1);
                div_next   = 46'(len_reg) << 14;
                q_next     = '0;
                step_next  = '0;
                state_next = mvn_pkg::N_DIV;
            end
            mvn_pkg::N_DIV:
            begin
                if (ge)
                begin
                    num_next = num_reg - div_reg;
                end
                q_next    = q_fin;
                div_next  = div_reg >> 1;
                step_next = step_reg + 4'd1;
                if (step_reg == 4'd14)
                begin
                    nrm_next[comp_reg] = neg_sel ? -16'(q_clamp) : 16'(q_clamp);
                    if (comp_reg == 2'd2)
                    begin
                        state_next = mvn_pkg::N_DONE;
                    end
                    else
                    begin
                        comp_next  = comp_reg + 2'd1;
                        state_next = mvn_pkg::N_DSET;
                    end
                end
            end
            mvn_pkg::N_DONE:
            begin
                state_next = mvn_pkg::N_IDLE;
            end
            default:
            begin
                state_next = mvn_pkg::N_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mvn_pkg::N_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        comp_reg <= comp_next;
        sum_reg  <= sum_next;
        n_reg    <= n_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
        len_reg  <= len_next;
        num_reg  <= num_next;
        div_reg  <= div_next;
        q_reg    <= q_next;
        step_reg <= step_next;
        nrm_reg  <= nrm_next;
        zero_reg <= zero_next;
    end

endmodule

FILE: hw/rtl/mvn_back.sv
`include "assert_macros.svh"

module mvn_back #(
    parameter int VERTEX_COUNT  = 1024,
    parameter int POSITION_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  mvn_pkg::q_entry_t  head,
    output logic               pop,
    input  logic               shading_mode,
    output logic               result_valid,
    output mvn_pkg::out_item_t result
);

    localparam int AW = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
    localparam int PB = POSITION_BITS;
    localparam int EW = PB + 1;
    localparam int PW = 2 * EW;
    localparam int DW = PW + 1;

    mvn_pkg::back_state_t state_reg;
    mvn_pkg::back_state_t state_next;
    mvn_pkg::q_entry_t    cur_reg;
    mvn_pkg::q_entry_t    cur_next;

    // Vertex position and normal sum tables.
    logic [3*PB-1:0]      pos_mem [VERTEX_COUNT];
    mvn_pkg::sum3_t       nrm_mem [VERTEX_COUNT];
    logic                 pos_we;
    logic [AW-1:0]        pos_waddr;
    logic [3*PB-1:0]      pos_wdata;
    logic [AW-1:0]        pos_raddr;
    logic [3*PB-1:0]      pos_rdata_reg;
    logic                 nrm_we;
    logic [AW-1:0]        nrm_waddr;
    mvn_pkg::sum3_t       nrm_wdata;
    logic [AW-1:0]        nrm_raddr;
    mvn_pkg::sum3_t       nrm_rdata_reg;

    logic signed [PB-1:0] pa_reg [3];
    logic signed [PB-1:0] pa_next [3];
    logic signed [PB-1:0] pb_reg [3];
    logic signed [PB-1:0] pb_next [3];
    logic signed [PB-1:0] prd [3];
    logic signed [EW-1:0] e1_reg [3];
    logic signed [EW-1:0] e1_next [3];
    logic signed [EW-1:0] e2_reg [3];
    logic signed [EW-1:0] e2_next [3];
    logic signed [PW-1:0] prod_reg [6];
    logic signed [PW-1:0] prod_next [6];
    logic signed [47:0]   f_reg [3];
    logic signed [47:0]   f_next [3];
    logic signed [DW-1:0] diff [3];
    logic signed [63:0]   diff64 [3];
    logic signed [47:0]   old_sum [3];
    logic signed [48:0]   acc [3];
    logic signed [47:0]   acc_sat [3];
    logic                 acc_ovf [3];
    logic                 sat_reg;
    logic                 sat_next;
    logic [1:0]           corner_reg;
    logic [1:0]           corner_next;
    logic [mvn_pkg::IDX_W-1:0] corner_idx;

    mvn_pkg::out_item_t   result_reg;
    mvn_pkg::out_item_t   result_next;
    logic                 result_valid_reg;
    logic                 result_valid_next;

    logic                 norm_go;
    logic                 norm_done;
    mvn_pkg::norm_res_t   norm_res;

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    mvn_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (norm_go),
        .sums  (nrm_rdata_reg),
        .done  (norm_done),
        .res   (norm_res)
    );

    // Table ports; read data is registered.
    always_ff @(posedge clk)
    begin
        if (pos_we)
        begin
            pos_mem[pos_waddr] <= pos_wdata;
        end
        pos_rdata_reg <= pos_mem[pos_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (nrm_we)
        begin
            nrm_mem[nrm_waddr] <= nrm_wdata;
        end
        nrm_rdata_reg <= nrm_mem[nrm_raddr];
    end

    // Corner picked for the normal read-modify-write.
    always_comb
    begin
        unique case (corner_reg)
            2'd0:    corner_idx = cur_reg.item.vertex_index;
            2'd1:    corner_idx = cur_reg.item.corner_b;
            default: corner_idx = cur_reg.item.corner_c;
        endcase
    end

    // Face normal arithmetic and saturating accumulation.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            prd[k] = pos_rdata_reg[k*PB +: PB];
        end
        diff[0] = DW'(prod_reg[0]) - DW'(prod_reg[1]);
        diff[1] = DW'(prod_reg[2]) - DW'(prod_reg[3]);
        diff[2] = DW'(prod_reg[4]) - DW'(prod_reg[5]);
        old_sum[0] = nrm_rdata_reg.x;
        old_sum[1] = nrm_rdata_reg.y;
        old_sum[2] = nrm_rdata_reg.z;
        for (int k = 0; k < 3; k++)
        begin
            diff64[k]  = 64'(diff[k]);
            acc[k]     = 49'(old_sum[k]) + 49'(f_reg[k]);
            acc_ovf[k] = (acc[k][48] != acc[k][47]);
            if (acc_ovf[k])
            begin
                acc_sat[k] = acc[k][48] ? 48'(mvn_pkg::SUM_MIN) : 48'(mvn_pkg::SUM_MAX);
            end
            else
            begin
                acc_sat[k] = acc[k][47:0];
            end
        end
    end

    // Back-end sequencer.
    always_comb
    begin
        state_next        = state_reg;
        cur_next          = cur_reg;
        pa_next           = pa_reg;
        pb_next           = pb_reg;
        e1_next           = e1_reg;
        e2_next           = e2_reg;
        prod_next         = prod_reg;
        f_next            = f_reg;
        sat_next          = sat_reg;
        corner_next       = corner_reg;
        result_next       = result_reg;
        result_valid_next = 1'b0;
        pop               = 1'b0;
        norm_go           = 1'b0;
        pos_we            = 1'b0;
        pos_waddr         = AW'(cur_reg.item.vertex_index);
        pos_wdata         = {PB'(cur_reg.item.pos_z), PB'(cur_reg.item.pos_y),
                             PB'(cur_reg.item.pos_x)};
        pos_raddr         = AW'(cur_reg.item.vertex_index);
        nrm_we            = 1'b0;
        nrm_waddr         = AW'(corner_idx);
        nrm_wdata         = '0;
        nrm_raddr         = AW'(corner_idx);
        unique case (state_reg)
            mvn_pkg::B_IDLE:
            begin
                if (head_valid)
                begin
                    pop      = 1'b1;
                    cur_next = head;
                    unique case (head.kind)
                        mvn_pkg::KIND_LOAD:     state_next = mvn_pkg::B_LOAD;
                        mvn_pkg::KIND_TRIANGLE: state_next = mvn_pkg::B_TA;
                        mvn_pkg::KIND_READ:     state_next = mvn_pkg::B_RD;
                        mvn_pkg::KIND_ZERO_LEN:
                        begin
                            result_next       = '0;
                            result_next.status = mvn_pkg::STATUS_ZERO_LEN;
                            result_valid_next = 1'b1;
                        end
                        default:
                        begin
                            result_next       = '0;
                            result_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            mvn_pkg::B_LOAD:
            begin
                pos_we            = 1'b1;
                nrm_we            = 1'b1;
                nrm_waddr         = AW'(cur_reg.item.vertex_index);
                result_next       = '0;
                result_valid_next = 1'b1;
                state_next        = mvn_pkg::B_IDLE;
            end
            mvn_pkg::B_TA:
            begin
                state_next = mvn_pkg::B_TB;
            end
            mvn_pkg::B_TB:
            begin
                pa_next    = prd;
                pos_raddr  = AW'(cur_reg.item.corner_b);
                state_next = mvn_pkg::B_TC;
            end
            mvn_pkg::B_TC:
            begin
                pb_next    = prd;
                pos_raddr  = AW'(cur_reg.item.corner_c);
                state_next = mvn_pkg::B_TE;
            end
            mvn_pkg::B_TE:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    e1_next[k] = EW'(pb_reg[k]) - EW'(pa_reg[k]);
                    e2_next[k] = EW'(prd[k]) - EW'(pa_reg[k]);
                end
                state_next = mvn_pkg::B_TM;
            end
            mvn_pkg::B_TM:
            begin
                prod_next[0] = e1_reg[1] * e2_reg[2];
                prod_next[1] = e1_reg[2] * e2_reg[1];
                prod_next[2] = e1_reg[2] * e2_reg[0];
                prod_next[3] = e1_reg[0] * e2_reg[2];
                prod_next[4] = e1_reg[0] * e2_reg[1];
                prod_next[5] = e1_reg[1] * e2_reg[0];
                state_next   = mvn_pkg::B_TF;
            end
            mvn_pkg::B_TF:
            begin
                sat_next = 1'b0;
                for (int k = 0; k < 3; k++)
                begin
                    if (diff64[k] > mvn_pkg::SUM_MAX)
                    begin
                        f_next[k] = 48'(mvn_pkg::SUM_MAX);
                        sat_next  = 1'b1;
                    end
                    else if (diff64[k] < mvn_pkg::SUM_MIN)
                    begin
                        f_next[k] = 48'(mvn_pkg::SUM_MIN);
                        sat_next  = 1'b1;
                    end
                    else
                    begin
                        f_next[k] = diff64[k][47:0];
                    end
                end
                corner_next = 2'd0;
                state_next  = mvn_pkg::B_NRD;
            end
            mvn_pkg::B_NRD:
            begin
                state_next = mvn_pkg::B_NWR;
            end
            mvn_pkg::B_NWR:
            begin
                nrm_we = 1'b1;
                if (shading_mode)
                begin
                    nrm_wdata = '{x: acc_sat[0], y: acc_sat[1], z: acc_sat[2]};
                    if (acc_ovf[0] || acc_ovf[1] || acc_ovf[2])
                    begin
                        sat_next = 1'b1;
                    end
                end
                else
                begin
                    nrm_wdata = '{x: f_reg[0], y: f_reg[1], z: f_reg[2]};
                end
                if (corner_reg == 2'd2)
                begin
                    result_next        = '0;
                    result_next.status = (sat_next) ? mvn_pkg::STATUS_SAT
                                                    : mvn_pkg::STATUS_OK;
                    result_valid_next  = 1'b1;
                    state_next         = mvn_pkg::B_IDLE;
                end
                else
                begin
                    corner_next = corner_reg + 2'd1;
                    state_next  = mvn_pkg::B_NRD;
                end
            end
            mvn_pkg::B_RD:
            begin
                nrm_raddr  = AW'(cur_reg.item.vertex_index);
                state_next = mvn_pkg::B_RW;
            end
            mvn_pkg::B_RW:
            begin
                norm_go    = 1'b1;
                state_next = mvn_pkg::B_RN;
            end
            mvn_pkg::B_RN:
            begin
                if (norm_done)
                begin
                    result_next.normal_x = norm_res.nx;
                    result_next.normal_y = norm_res.ny;
                    result_next.normal_z = norm_res.nz;
                    result_next.status   = norm_res.zero_len ? mvn_pkg::STATUS_ZERO_LEN
                                                             : mvn_pkg::STATUS_OK;
                    result_valid_next    = 1'b1;
                    state_next           = mvn_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = mvn_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= mvn_pkg::B_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        pa_reg     <= pa_next;
        pb_reg     <= pb_next;
        e1_reg     <= e1_next;
        e2_reg     <= e2_next;
        prod_reg   <= prod_next;
        f_reg      <= f_next;
        sat_reg    <= sat_next;
        corner_reg <= corner_next;
        result_reg <= result_next;
    end

    `ASSERT_IMPLY(a_norm_done_owned, norm_done, state_reg == mvn_pkg::B_RN)
    `ASSERT_IMPLY(a_zero_len_zero,
        result_valid_reg && (result_reg.status == mvn_pkg::STATUS_ZERO_LEN),
        (result_reg.normal_x == '0) && (result_reg.normal_y == '0)
        && (result_reg.normal_z == '0))
    `ASSERT_IMPLY(a_unit_bound, result_valid_reg,
        (result_reg.normal_x <= 16'sd16384) && (result_reg.normal_x >= -16'sd16384))

endmodule

FILE: tb/mesh_vertex_normals_tb.sv
module mesh_vertex_normals_tb;

    localparam int  VERTICES          = 1024;
    localparam int  HALF_PERIOD       = 6;
    localparam int  READ_LATENCY      = 140;
    localparam logic [2:0] SHADING_MODE_ADDR = 3'd0;
    localparam logic MODE_FLAT        = 1'b0;
    localparam logic MODE_SMOOTH      = 1'b1;
    localparam longint SUM_HI         = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SUM_LO         = -64'sh0000_8000_0000_0000;

    logic                clk;
    logic                rst_n;
    logic                start;
    mvn_pkg::in_item_t   in_item;
    logic                busy;
    logic                result_valid;
    mvn_pkg::out_item_t  result;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    // Shadow copy of the vertex and normal tables and of the mode register.
    longint      vertex_pos [VERTICES][3];
    longint      normal_acc [VERTICES][3];
    logic        shading_mode;

    mvn_pkg::in_item_t   pending_items [$];
    mvn_pkg::out_item_t  expected_normals [$];
    bit          vertex_loaded [VERTICES];
    int          loaded_list [$];
    int          sender_idle_pct;
    int          fail_count;
    bit          took_beat;

    mesh_vertex_normals i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .in_item      (in_item),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Clock generation.
    always
    begin
        clk = 1'b1;
        #HALF_PERIOD;
        clk = 1'b0;
        #HALF_PERIOD;
    end

    // Saturate a value to the signed 48-bit range of a normal sum.
    function automatic longint clamp_sum(longint v, inout bit sat);
        if (v > SUM_HI)
        begin
            sat = 1'b1;
            return SUM_HI;
        end
        if (v < SUM_LO)
        begin
            sat = 1'b1;
            return SUM_LO;
        end
        return v;
    endfunction

    // Integer square root, rounded down.
    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned one;
        root = 0;
        one = 64'd1 << 62;
        while (one > n)
            one = one >> 2;
        while (one != 0)
        begin
            if (n >= root + one)
            begin
                n = n - (root + one);
                root = (root >> 1) + one;
            end
            else
                root = root >> 1;
            one = one >> 2;
        end
        return root;
    endfunction

    // Work out the result of one item and update the shadow tables.
    function automatic mvn_pkg::out_item_t vertex_normal_result(mvn_pkg::in_item_t it);
        mvn_pkg::out_item_t r;
        longint          e1 [3];
        longint          e2 [3];
        longint          face [3];
        int              corner [3];
        longint unsigned mag [3];
        bit              neg [3];
        longint unsigned peak;
        longint unsigned sq_sum;
        longint unsigned len;
        longint unsigned q;
        int              shift;
        bit              sat;
        r = '0;
        sat = 1'b0;
        case (mvn_pkg::op_t'(it.operation))
            mvn_pkg::OP_LOAD:
            begin
                vertex_pos[it.vertex_index][0] = longint'(it.pos_x);
                vertex_pos[it.vertex_index][1] = longint'(it.pos_y);
                vertex_pos[it.vertex_index][2] = longint'(it.pos_z);
                for (int k = 0; k < 3; k++)
                    normal_acc[it.vertex_index][k] = 0;
            end
            mvn_pkg::OP_TRIANGLE:
            begin
                corner[0] = it.vertex_index;
                corner[1] = it.corner_b;
                corner[2] = it.corner_c;
                for (int k = 0; k < 3; k++)
                begin
                    e1[k] = vertex_pos[corner[1]][k] - vertex_pos[corner[0]][k];
                    e2[k] = vertex_pos[corner[2]][k] - vertex_pos[corner[0]][k];
                end
                face[0] = clamp_sum(e1[1] * e2[2] - e1[2] * e2[1], sat);
                face[1] = clamp_sum(e1[2] * e2[0] - e1[0] * e2[2], sat);
                face[2] = clamp_sum(e1[0] * e2[1] - e1[1] * e2[0], sat);
                for (int c = 0; c < 3; c++)
                    for (int k = 0; k < 3; k++)
                        if (shading_mode == MODE_FLAT)
                            normal_acc[corner[c]][k] = face[k];
                        else
                            normal_acc[corner[c]][k] =
                                clamp_sum(normal_acc[corner[c]][k] + face[k], sat);
                if (sat)
                    r.status = mvn_pkg::STATUS_SAT;
            end
            mvn_pkg::OP_READ:
            begin
                peak = 0;
                for (int k = 0; k < 3; k++)
                begin
                    neg[k] = normal_acc[it.vertex_index][k] < 0;
                    mag[k] = neg[k] ? longint'(-normal_acc[it.vertex_index][k])
                                    : longint'(normal_acc[it.vertex_index][k]);
                    if (mag[k] > peak)
                        peak = mag[k];
                end
                shift = 0;
                while ((peak >> shift) >= (64'd1 << 30))
                    shift++;
                sq_sum = 0;
                for (int k = 0; k < 3; k++)
                begin
                    mag[k] = mag[k] >> shift;
                    sq_sum = sq_sum + mag[k] * mag[k];
                end
                len = int_sqrt(sq_sum);
                if (len == 0)
                    r.status = mvn_pkg::STATUS_ZERO_LEN;
                else
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        q = (mag[k] * 16384 + len / 2) / len;
                        if (q > 16384)
                            q = 16384;
                        if (neg[k])
                            q = -q;
                        case (k)
                            0: r.normal_x = q[15:0];
                            1: r.normal_y = q[15:0];
                            default: r.normal_z = q[15:0];
                        endcase
                    end
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // Driver: present the next pending item at the falling edge.
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (start && !took_beat)
            start <= 1'b1;
        else if (pending_items.size() > 0 &&
                 ($urandom_range(99) >= sender_idle_pct))
        begin
            start   <= 1'b1;
            in_item <= pending_items[0];
        end
        else
            start <= 1'b0;
        took_beat = 1'b0;
    end

    // An input beat is taken here; its expected result is queued at once.
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            expected_normals.push_back(vertex_normal_result(in_item));
            void'(pending_items.pop_front());
            took_beat = 1'b1;
        end
    end

    // Monitor: check each result beat against the oldest expectation.
    always @(posedge clk)
    begin
        mvn_pkg::out_item_t want;
        if (rst_n && result_valid)
        begin
            if (expected_normals.size() == 0)
            begin
                $error("result beat with no expected result");
                fail_count++;
            end
            else
            begin
                want = expected_normals.pop_front();
                if (result.normal_x !== want.normal_x)
                begin
                    $error("normal_x expected %0d got %0d", want.normal_x, result.normal_x);
                    fail_count++;
                end
                if (result.normal_y !== want.normal_y)
                begin
                    $error("normal_y expected %0d got %0d", want.normal_y, result.normal_y);
                    fail_count++;
                end
                if (result.normal_z !== want.normal_z)
                begin
                    $error("normal_z expected %0d got %0d", want.normal_z, result.normal_z);
                    fail_count++;
                end
                if (result.status !== want.status)
                begin
                    $error("status expected %0d got %0d", want.status, result.status);
                    fail_count++;
                end
            end
        end
    end

    // A coordinate biased toward the extremes and small values.
    function automatic logic [15:0] rand_coord();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2, 3: return 16'($signed($urandom_range(1023)) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic mvn_pkg::in_item_t make_item(mvn_pkg::op_t op, int a, int b, int c);
        mvn_pkg::in_item_t it;
        it.operation    = op;
        it.vertex_index = a[9:0];
        it.corner_b     = b[9:0];
        it.corner_c     = c[9:0];
        it.pos_x        = rand_coord();
        it.pos_y        = rand_coord();
        it.pos_z        = rand_coord();
        return it;
    endfunction

    task automatic send(mvn_pkg::op_t op, int a, int b, int c);
        pending_items.push_back(make_item(op, a, b, c));
        if (op == mvn_pkg::OP_LOAD && !vertex_loaded[a])
        begin
            vertex_loaded[a] = 1'b1;
            loaded_list.push_back(a);
        end
    endtask

    task automatic load_at(int a, logic [15:0] x, logic [15:0] y, logic [15:0] z);
        mvn_pkg::in_item_t it;
        it = make_item(mvn_pkg::OP_LOAD, a, $urandom_range(1023), $urandom_range(1023));
        it.pos_x = x;
        it.pos_y = y;
        it.pos_z = z;
        pending_items.push_back(it);
        if (!vertex_loaded[a])
        begin
            vertex_loaded[a] = 1'b1;
            loaded_list.push_back(a);
        end
    endtask

    function automatic int any_loaded();
        return loaded_list[$urandom_range(loaded_list.size() - 1)];
    endfunction

    // Random traffic: mostly load-triangle-read sequences, plus noise.
    task automatic add_random_items(int count);
        int n;
        int v [3];
        n = 0;
        while (n < count)
        begin
            if ($urandom_range(99) < 55)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    if ($urandom_range(2) == 0)
                        v[k] = any_loaded();
                    else
                    begin
                        v[k] = $urandom_range(1023);
                        send(mvn_pkg::OP_LOAD, v[k], $urandom_range(1023),
                             $urandom_range(1023));
                        n++;
                    end
                end
                send(mvn_pkg::OP_TRIANGLE, v[0], v[1], v[2]);
                send(mvn_pkg::OP_READ, v[$urandom_range(2)], $urandom_range(1023),
                     $urandom_range(1023));
                n += 2;
            end
            else
            begin
                case ($urandom_range(9))
                    0, 1: send(mvn_pkg::OP_LOAD, $urandom_range(1023),
                               $urandom_range(1023), $urandom_range(1023));
                    2, 3: send(mvn_pkg::OP_TRIANGLE, any_loaded(), any_loaded(),
                               any_loaded());
                    4:
                    begin
                        v[0] = any_loaded();
                        send(mvn_pkg::OP_TRIANGLE, v[0], v[0], any_loaded());
                    end
                    5, 6, 7: send(mvn_pkg::OP_READ, any_loaded(), $urandom_range(1023),
                                  $urandom_range(1023));
                    default: send(mvn_pkg::OP_NONE, $urandom_range(1023),
                                  $urandom_range(1023), $urandom_range(1023));
                endcase
                n++;
            end
        end
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || expected_normals.size() > 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
    endtask

    // Register write then read back over the configuration port.
    task automatic write_mode(logic mode);
        logic [31:0] data;
        data    = $urandom;
        data[0] = mode;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SHADING_MODE_ADDR;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        shading_mode = mode;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[0] !== mode)
        begin
            $error("shading_mode expected %0d got %0d", mode, prdata[0]);
            fail_count++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin
        fail_count      = 0;
        shading_mode    = MODE_SMOOTH;
        sender_idle_pct = 0;
        took_beat       = 1'b0;
        rst_n   = 1'b0;
        start   = 1'b0;
        in_item = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: unit triangle, extremes, repeated corner, zero length.
        load_at(0, 16'h0000, 16'h0000, 16'h0000);
        load_at(1, 16'h0100, 16'h0000, 16'h0000);
        load_at(2, 16'h0000, 16'h0100, 16'h0000);
        send(mvn_pkg::OP_TRIANGLE, 0, 1, 2);
        send(mvn_pkg::OP_READ, 0, 0, 0);
        load_at(1023, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send(mvn_pkg::OP_READ, 1023, 1023, 1023);
        load_at(512, 16'h8000, 16'h8000, 16'h8000);
        send(mvn_pkg::OP_TRIANGLE, 0, 0, 1);
        send(mvn_pkg::OP_READ, 1, 0, 0);
        send(mvn_pkg::OP_TRIANGLE, 1023, 512, 2);
        send(mvn_pkg::OP_TRIANGLE, 512, 1023, 1);
        send(mvn_pkg::OP_READ, 2, 0, 0);
        send(mvn_pkg::OP_READ, 512, 0, 0);
        send(mvn_pkg::OP_NONE, 1023, 1023, 1023);
        send(mvn_pkg::OP_TRIANGLE, 0, 1, 2);
        send(mvn_pkg::OP_READ, 0, 0, 0);
        send(mvn_pkg::OP_TRIANGLE, 2, 1, 2);
        send(mvn_pkg::OP_READ, 2, 0, 0);
        drain();

        write_mode(MODE_FLAT);
        send(mvn_pkg::OP_TRIANGLE, 2, 1, 0);
        send(mvn_pkg::OP_READ, 0, 0, 0);
        add_random_items(300);
        drain();

        write_mode(MODE_SMOOTH);
        sender_idle_pct = 76;
        add_random_items(300);
        drain();

        write_mode(MODE_FLAT);
        sender_idle_pct = 13;
        add_random_items(300);
        drain();

        write_mode(MODE_SMOOTH);
        sender_idle_pct = 0;
        add_random_items(300);
        drain();

        while (expected_normals.size() > 0)
            @(posedge clk);
        repeat (READ_LATENCY) @(posedge clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #(2 * HALF_PERIOD * 4_000_000);
        $display("Mismatches found");
        $finish;
    end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/mvn_pkg.sv
hw/rtl/mvn_front.sv
hw/rtl/mvn_norm.sv
hw/rtl/mvn_back.sv
hw/rtl/mesh_vertex_normals.sv
tb/mesh_vertex_normals_tb.sv
